[design/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same check, message names the result channel.
`define ASSERT_OUT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("result channel check failed");

`endif

[design/swsfr_pkg.sv]
package swsfr_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TIMER = 2'd1,
    ACT_EDGE  = 2'd2,
    ACT_CHECK = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    PH_STOPPED   = 4'd0,
    PH_HOST_LOW  = 4'd1,
    PH_HOST_HIGH = 4'd2,
    PH_WAIT_RESP = 4'd3,
    PH_SENS_HIGH = 4'd4,
    PH_XFER      = 4'd5,
    PH_CHECK     = 4'd6,
    PH_READY     = 4'd7,
    PH_CS_ERR    = 4'd8,
    PH_NO_RESP   = 4'd9
  } phase_t;

  // configuration register indexes
  localparam logic [2:0] REG_HOST_LOW_PERIODS = 3'd0;
  localparam logic [2:0] REG_HOST_HIGH_TIME   = 3'd1;
  localparam logic [2:0] REG_RESP_WIDTH_LOW   = 3'd2;
  localparam logic [2:0] REG_RESP_WIDTH_HIGH  = 3'd3;
  localparam logic [2:0] REG_ZERO_WIDTH_LOW   = 3'd4;
  localparam logic [2:0] REG_BIT_SPLIT_WIDTH  = 3'd5;
  localparam logic [2:0] REG_ONE_WIDTH_HIGH   = 3'd6;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] COMPARE_MAX = 8'd255;

  typedef struct packed {
    action_t    action;
    logic [7:0] pulse_width;
  } item_t;

  typedef struct packed {
    logic listen;
    logic drive_low;
    logic rising;
    logic timer_on;
  } line_ctl_t;

  typedef struct packed {
    phase_t            state_code;
    logic              start_accepted;
    logic              line_drive_low;
    logic              line_is_input;
    logic              edge_is_rising;
    logic [7:0]        timer_compare;
    logic              timer_running;
    logic [7:0]        humidity_whole;
    logic [3:0]        humidity_tenths;
    logic signed [7:0] temperature_whole;
    logic [3:0]        temperature_tenths;
  } result_t;

endpackage

[design/swsfr_in_stage.sv]
module swsfr_in_stage
  import swsfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  consume,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  item_t item_r;

  assign in_stall   = valid_r && !consume;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

[design/swsfr_core.sv]
module swsfr_core
  import swsfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  advance,
  input  item_t                 item,
  output result_t               result_nxt
);

  localparam logic [16:0] RECIP10 = 17'd52429;  // ceil(2^19 / 10)

  logic [7:0] reg_periods_r, reg_high_time_r, reg_resp_lo_r, reg_resp_hi_r;
  logic [7:0] reg_zero_lo_r, reg_split_r, reg_one_hi_r;

  phase_t    phase_r, phase_nxt;
  logic [7:0] lpc_r, lpc_nxt;
  logic [5:0] bits_r, bits_nxt;
  logic [15:0] hum_r, hum_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [7:0] csum_r, csum_nxt;
  line_ctl_t lc_r, lc_nxt;
  logic [7:0] cmp_r, cmp_nxt;
  logic       accepted;

  logic       resp_ok, zero_ok, one_ok;
  logic [7:0] byte_sum;

  logic [32:0] hum_prod;
  logic [31:0] mag_prod;
  logic [12:0] hum_q, mag_q;
  logic [15:0] hum_rem;
  logic [14:0] mag, mag_rem;
  logic [7:0]  temp_whole;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_periods_r   <= 8'd2;
      reg_high_time_r <= 8'd40;
      reg_resp_lo_r   <= 8'd60;
      reg_resp_hi_r   <= 8'd100;
      reg_zero_lo_r   <= 8'd50;
      reg_split_r     <= 8'd110;
      reg_one_hi_r    <= 8'd160;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_HOST_LOW_PERIODS: reg_periods_r   <= cfg_wdata;
        REG_HOST_HIGH_TIME:   reg_high_time_r <= cfg_wdata;
        REG_RESP_WIDTH_LOW:   reg_resp_lo_r   <= cfg_wdata;
        REG_RESP_WIDTH_HIGH:  reg_resp_hi_r   <= cfg_wdata;
        REG_ZERO_WIDTH_LOW:   reg_zero_lo_r   <= cfg_wdata;
        REG_BIT_SPLIT_WIDTH:  reg_split_r     <= cfg_wdata;
        REG_ONE_WIDTH_HIGH:   reg_one_hi_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STOPPED;
      lpc_r   <= 8'd0;
      bits_r  <= 6'd0;
      hum_r   <= 16'd0;
      temp_r  <= 16'd0;
      csum_r  <= 8'd0;
      lc_r    <= '{listen: 1'b0, drive_low: 1'b0, rising: 1'b1, timer_on: 1'b0};
      cmp_r   <= COMPARE_MAX;
    end else if (advance) begin
      phase_r <= phase_nxt;
      lpc_r   <= lpc_nxt;
      bits_r  <= bits_nxt;
      hum_r   <= hum_nxt;
      temp_r  <= temp_nxt;
      csum_r  <= csum_nxt;
      lc_r    <= lc_nxt;
      cmp_r   <= cmp_nxt;
    end
  end

  assign resp_ok = (item.pulse_width > reg_resp_lo_r) && (item.pulse_width < reg_resp_hi_r);
  assign zero_ok = (item.pulse_width > reg_zero_lo_r) && (item.pulse_width <= reg_split_r);
  assign one_ok  = (item.pulse_width > reg_split_r) && (item.pulse_width <= reg_one_hi_r);
  assign byte_sum = hum_r[15:8] + hum_r[7:0] + temp_r[15:8] + temp_r[7:0];

  // next state
  always_comb begin
    phase_nxt = phase_r;
    lpc_nxt   = lpc_r;
    bits_nxt  = bits_r;
    hum_nxt   = hum_r;
    temp_nxt  = temp_r;
    csum_nxt  = csum_r;
    lc_nxt    = lc_r;
    cmp_nxt   = cmp_r;
    accepted  = 1'b0;
    case (item.action)
      ACT_START: begin
        if (phase_r inside {PH_STOPPED, PH_READY, PH_CS_ERR, PH_NO_RESP}) begin
          hum_nxt          = 16'd0;
          temp_nxt         = 16'd0;
          csum_nxt         = 8'd0;
          lpc_nxt          = 8'd0;
          bits_nxt         = 6'd0;
          lc_nxt.listen    = 1'b0;
          lc_nxt.drive_low = 1'b1;
          lc_nxt.timer_on  = 1'b1;
          cmp_nxt          = COMPARE_MAX;
          phase_nxt        = PH_HOST_LOW;
          accepted         = 1'b1;
        end
      end
      ACT_TIMER: begin
        if (lc_r.timer_on) begin
          case (phase_r)
            PH_HOST_LOW: begin
              if (reg_periods_r != 8'd0 && lpc_r < reg_periods_r - 8'd1) begin
                lpc_nxt = lpc_r + 8'd1;
              end else begin
                lc_nxt.drive_low = 1'b0;
                lpc_nxt          = 8'd0;
                phase_nxt        = PH_HOST_HIGH;
                cmp_nxt          = reg_high_time_r;
              end
            end
            PH_HOST_HIGH: begin
              cmp_nxt   = COMPARE_MAX;
              lc_nxt    = '{listen: 1'b1, drive_low: 1'b0, rising: 1'b1, timer_on: 1'b1};
              phase_nxt = PH_WAIT_RESP;
            end
            default: begin
              // sensor timed out while listening: back to driven high, timer off
              phase_nxt        = PH_NO_RESP;
              lc_nxt.listen    = 1'b0;
              lc_nxt.drive_low = 1'b0;
              lc_nxt.timer_on  = 1'b0;
              bits_nxt         = 6'd0;
            end
          endcase
        end
      end
      ACT_EDGE: begin
        if (lc_r.listen) begin
          if (phase_r == PH_WAIT_RESP && resp_ok) begin
            lc_nxt.rising = 1'b0;
            phase_nxt     = PH_SENS_HIGH;
          end else if (phase_r == PH_SENS_HIGH && resp_ok) begin
            phase_nxt = PH_XFER;
          end else if (phase_r == PH_XFER) begin
            if (zero_ok) begin
              bits_nxt = bits_r + 6'd1;
            end else if (one_ok) begin
              // MSB first: bit n lands at 15-n, 31-n or 39-n
              case (bits_r[5:4])
                2'b00:   hum_nxt[~bits_r[3:0]]  = 1'b1;
                2'b01:   temp_nxt[~bits_r[3:0]] = 1'b1;
                2'b10:   csum_nxt[~bits_r[2:0]] = 1'b1;
                default: ;
              endcase
              bits_nxt = bits_r + 6'd1;
            end
            if (bits_nxt > 6'd39) begin
              lc_nxt.listen    = 1'b0;
              lc_nxt.drive_low = 1'b0;
              lc_nxt.timer_on  = 1'b0;
              bits_nxt         = 6'd0;
              phase_nxt        = PH_CHECK;
            end
          end
        end
      end
      ACT_CHECK: begin
        if (phase_r == PH_CHECK) begin
          phase_nxt = (csum_r == byte_sum) ? PH_READY : PH_CS_ERR;
        end
      end
      default: ;
    endcase
  end

  // Readings come from the stored frame; it never changes on the way into ready.
  assign mag      = temp_r[14:0];
  assign hum_prod = hum_r * RECIP10;
  assign mag_prod = mag * RECIP10;
  assign hum_q    = hum_prod[31:19];
  assign mag_q    = mag_prod[31:19];
  assign hum_rem  = hum_r - 16'({hum_q, 3'b000} + {hum_q, 1'b0});
  assign mag_rem  = mag - 15'({mag_q, 3'b000} + {mag_q, 1'b0});
  assign temp_whole = temp_r[15] ? 8'(8'd0 - mag_q[7:0]) : mag_q[7:0];

  // result
  always_comb begin
    result_nxt                    = '0;
    result_nxt.state_code         = phase_nxt;
    result_nxt.start_accepted     = accepted;
    result_nxt.line_drive_low     = !lc_nxt.listen && lc_nxt.drive_low;
    result_nxt.line_is_input      = lc_nxt.listen;
    result_nxt.edge_is_rising     = lc_nxt.rising;
    result_nxt.timer_compare      = cmp_nxt;
    result_nxt.timer_running      = lc_nxt.timer_on;
    if (phase_nxt == PH_READY) begin
      result_nxt.humidity_whole     = hum_q[7:0];
      result_nxt.humidity_tenths    = hum_rem[3:0];
      result_nxt.temperature_whole  = temp_whole;
      result_nxt.temperature_tenths = mag_rem[3:0];
    end
  end

endmodule

[design/swsfr_out_stage.sv]
module swsfr_out_stage
  import swsfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result_nxt,
  input  logic    out_stall,
  output logic    can_load,
  output logic    out_valid,
  output result_t result
);

  logic    valid_r;
  result_t result_r;

  assign can_load  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign result    = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

endmodule

[design/single_wire_sensor_frame_reader.sv]
// A result is offered after its input transfer passes the input register and
// then the state update into the result register; an output stall can hold it.
// Throughput: one item per cycle while out_stall is low; the state update
// and divide-by-ten multiplies sit in a single stage between the two registers.
// Reset (rst_n low, synchronous): clears the pipeline valids, the frame state
// and line control, and loads the configuration registers with their defaults.
module single_wire_sensor_frame_reader
  import swsfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_pulse_width,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            out_state_code,
  output logic                  out_start_accepted,
  output logic                  out_line_drive_low,
  output logic                  out_line_is_input,
  output logic                  out_edge_is_rising,
  output logic [7:0]            out_timer_compare,
  output logic                  out_timer_running,
  output logic [7:0]            out_humidity_whole,
  output logic [3:0]            out_humidity_tenths,
  output logic signed [7:0]     out_temperature_whole,
  output logic [3:0]            out_temperature_tenths
);

  item_t   in_item, item;
  logic    item_valid, can_load, advance;
  result_t result_nxt, result;

  assign in_item.action      = action_t'(in_action);
  assign in_item.pulse_width = in_pulse_width;
  assign advance             = item_valid && can_load;

  swsfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .consume    (can_load),
    .item_valid (item_valid),
    .item       (item)
  );

  swsfr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .advance    (advance),
    .item       (item),
    .result_nxt (result_nxt)
  );

  swsfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result_nxt (result_nxt),
    .out_stall  (out_stall),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .result     (result)
  );

  assign out_state_code         = result.state_code;
  assign out_start_accepted     = result.start_accepted;
  assign out_line_drive_low     = result.line_drive_low;
  assign out_line_is_input      = result.line_is_input;
  assign out_edge_is_rising     = result.edge_is_rising;
  assign out_timer_compare      = result.timer_compare;
  assign out_timer_running      = result.timer_running;
  assign out_humidity_whole     = result.humidity_whole;
  assign out_humidity_tenths    = result.humidity_tenths;
  assign out_temperature_whole  = result.temperature_whole;
  assign out_temperature_tenths = result.temperature_tenths;

endmodule

[design/swsfr_checker.sv]
`include "assert_macros.svh"

module swsfr_checker
  import swsfr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [3:0]        out_state_code,
  input logic              out_start_accepted,
  input logic              out_line_drive_low,
  input logic              out_line_is_input,
  input logic              out_timer_running,
  input logic [7:0]        out_humidity_whole,
  input logic [3:0]        out_humidity_tenths,
  input logic signed [7:0] out_temperature_whole,
  input logic [3:0]        out_temperature_tenths
);

  // stalled result holds
  `ASSERT_OUT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_state_code) && $stable(out_humidity_whole))

  // readings are blank outside the ready phase
  `ASSERT_OUT(a_blank_readings, clk, rst_n, out_valid && out_state_code != PH_READY |-> out_humidity_whole == 8'd0 && out_humidity_tenths == 4'd0 && out_temperature_whole == 8'sd0 && out_temperature_tenths == 4'd0)

  // an accepted start always lands in the host low phase
  `ASSERT_CLK(a_start_phase, clk, rst_n, out_valid && out_start_accepted |-> out_state_code == PH_HOST_LOW)

  // listening always runs the timeout timer and never drives low
  `ASSERT_CLK(a_listen_timer, clk, rst_n, out_valid && out_line_is_input |-> out_timer_running && !out_line_drive_low)

endmodule

bind single_wire_sensor_frame_reader swsfr_checker u_swsfr_checker (.*);

[tb/sv/single_wire_sensor_frame_reader_tb.sv]
module single_wire_sensor_frame_reader_tb;
  import swsfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int SEG_ITEMS = 50;
  localparam int NUM_SETS = 6;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam result_t BLANK = '0;

  typedef struct {
    action_t    act;
    logic [7:0] width;
    bit         typed;
    result_t    res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [7:0] in_pulse_width = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_state_code;
  logic out_start_accepted;
  logic out_line_drive_low;
  logic out_line_is_input;
  logic out_edge_is_rising;
  logic [7:0] out_timer_compare;
  logic out_timer_running;
  logic [7:0] out_humidity_whole;
  logic [3:0] out_humidity_tenths;
  logic signed [7:0] out_temperature_whole;
  logic [3:0] out_temperature_tenths;

  single_wire_sensor_frame_reader u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_addr               (cfg_addr),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_pulse_width         (in_pulse_width),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_state_code         (out_state_code),
    .out_start_accepted     (out_start_accepted),
    .out_line_drive_low     (out_line_drive_low),
    .out_line_is_input      (out_line_is_input),
    .out_edge_is_rising     (out_edge_is_rising),
    .out_timer_compare      (out_timer_compare),
    .out_timer_running      (out_timer_running),
    .out_humidity_whole     (out_humidity_whole),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_temperature_whole  (out_temperature_whole),
    .out_temperature_tenths (out_temperature_tenths)
  );

  // predicted reader state
  logic [7:0]  cfg_regs [7] = '{8'd2, 8'd40, 8'd60, 8'd100, 8'd50, 8'd110, 8'd160};
  phase_t      rd_phase = PH_STOPPED;
  logic [7:0]  rd_low_cnt = '0;
  logic [5:0]  rd_bits = '0;
  logic [15:0] rd_hum = '0;
  logic [15:0] rd_temp = '0;
  logic [7:0]  rd_csum = '0;
  line_ctl_t   rd_line = '{listen: 1'b0, drive_low: 1'b0, rising: 1'b1, timer_on: 1'b0};
  logic [7:0]  rd_cmp = COMPARE_MAX;

  result_t pending_status_q[$];
  result_t head_r;
  int err_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 83;

  logic [7:0] cfg_sets [NUM_SETS][7] = '{
    '{8'd0,   8'd1,   8'd0,   8'd255, 8'd0,   8'd127, 8'd255},
    '{8'd3,   8'd128, 8'd10,  8'd40,  8'd20,  8'd30,  8'd255},
    '{8'd255, 8'd255, 8'd200, 8'd202, 8'd200, 8'd100, 8'd120},
    '{8'd1,   8'd200, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0},
    '{8'd2,   8'd40,  8'd60,  8'd100, 8'd50,  8'd110, 8'd160},
    '{8'd2,   8'd60,  8'd30,  8'd90,  8'd35,  8'd75,  8'd140}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t status_word(phase_t p, bit acc, bit low, bit inp, bit rise,
                                          logic [7:0] cmp, bit tmr);
    result_t r;
    r = '0;
    r.state_code = p;
    r.start_accepted = acc;
    r.line_drive_low = low;
    r.line_is_input = inp;
    r.edge_is_rising = rise;
    r.timer_compare = cmp;
    r.timer_running = tmr;
    return r;
  endfunction

  // line back to output, driven high; edge polarity kept
  function automatic void drop_line();
    rd_line.listen = 1'b0;
    rd_line.drive_low = 1'b0;
    rd_line.timer_on = 1'b0;
    rd_bits = '0;
  endfunction

  function automatic result_t sensor_step(action_t act, logic [7:0] w);
    result_t r;
    bit acc;
    bit resp_ok;
    logic [7:0] sum8;
    logic [14:0] mag;
    logic [7:0] tw;
    r = '0;
    acc = 1'b0;
    case (act)
      ACT_START: begin
        if (rd_phase inside {PH_STOPPED, PH_READY, PH_CS_ERR, PH_NO_RESP}) begin
          rd_hum = '0;
          rd_temp = '0;
          rd_csum = '0;
          rd_low_cnt = '0;
          rd_bits = '0;
          rd_line.listen = 1'b0;
          rd_line.drive_low = 1'b1;
          rd_line.timer_on = 1'b1;
          rd_cmp = COMPARE_MAX;
          rd_phase = PH_HOST_LOW;
          acc = 1'b1;
        end
      end
      ACT_TIMER: begin
        if (rd_line.timer_on) begin
          if (rd_phase == PH_HOST_LOW) begin
            if (cfg_regs[REG_HOST_LOW_PERIODS] != 8'd0 &&
                rd_low_cnt < cfg_regs[REG_HOST_LOW_PERIODS] - 8'd1) begin
              rd_low_cnt++;
            end else begin
              rd_line.drive_low = 1'b0;
              rd_low_cnt = '0;
              rd_phase = PH_HOST_HIGH;
              rd_cmp = cfg_regs[REG_HOST_HIGH_TIME];
            end
          end else if (rd_phase == PH_HOST_HIGH) begin
            rd_cmp = COMPARE_MAX;
            rd_line = '{listen: 1'b1, drive_low: 1'b0, rising: 1'b1, timer_on: 1'b1};
            rd_phase = PH_WAIT_RESP;
          end else begin
            rd_phase = PH_NO_RESP;
            drop_line();
          end
        end
      end
      ACT_EDGE: begin
        if (rd_line.listen) begin
          resp_ok = w > cfg_regs[REG_RESP_WIDTH_LOW] && w < cfg_regs[REG_RESP_WIDTH_HIGH];
          if (rd_phase == PH_WAIT_RESP && resp_ok) begin
            rd_line.rising = 1'b0;
            rd_phase = PH_SENS_HIGH;
          end else if (rd_phase == PH_SENS_HIGH && resp_ok) begin
            rd_phase = PH_XFER;
          end else begin
            // zero window wins where the windows meet
            if (rd_phase == PH_XFER && w > cfg_regs[REG_ZERO_WIDTH_LOW] &&
                w <= cfg_regs[REG_BIT_SPLIT_WIDTH]) begin
              rd_bits++;
            end else if (rd_phase == PH_XFER && w > cfg_regs[REG_BIT_SPLIT_WIDTH] &&
                         w <= cfg_regs[REG_ONE_WIDTH_HIGH]) begin
              if (rd_bits < 16) rd_hum[15 - rd_bits] = 1'b1;
              else if (rd_bits < 32) rd_temp[31 - rd_bits] = 1'b1;
              else rd_csum[39 - rd_bits] = 1'b1;
              rd_bits++;
            end
            if (rd_bits > 39) begin
              drop_line();
              rd_phase = PH_CHECK;
            end
          end
        end
      end
      ACT_CHECK: begin
        if (rd_phase == PH_CHECK) begin
          sum8 = rd_hum[15:8] + rd_hum[7:0] + rd_temp[15:8] + rd_temp[7:0];
          rd_phase = (rd_csum == sum8) ? PH_READY : PH_CS_ERR;
        end
      end
      default: ;
    endcase

    r = status_word(rd_phase, acc, !rd_line.listen && rd_line.drive_low, rd_line.listen,
                    rd_line.rising, rd_cmp, rd_line.timer_on);
    if (rd_phase == PH_READY) begin
      mag = rd_temp[14:0];
      tw = 8'(mag / 10);
      if (rd_temp[15]) tw = -tw;
      r.humidity_whole = 8'(rd_hum / 10);
      r.humidity_tenths = 4'(rd_hum % 10);
      r.temperature_whole = tw;
      r.temperature_tenths = 4'(mag % 10);
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_item(input action_t a, input logic [7:0] w, input bit typed,
                           input result_t res);
    result_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= a;
    in_pulse_width <= w;
    do @(posedge clk); while (in_stall);
    p = sensor_step(a, w);
    pending_status_q.push_back(typed ? res : p);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push_noise();
    push_item(action_t'($urandom_range(3)), 8'($urandom), 1'b0, BLANK);
  endtask

  task automatic wait_results_idle();
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic load_cfg(input int s);
    for (int i = 0; i <= REG_UNUSED; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr <= 3'(i);
      if (i < 7) begin
        cfg_wdata <= cfg_sets[s][i];
        cfg_regs[i] = cfg_sets[s][i];
      end else begin
        cfg_wdata <= 8'($urandom);
      end
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // one read: start, host pulse, response, 40 bits, then the checksum check; a rare timeout can abort it
  task automatic run_frame();
    logic [15:0] hum;
    logic [15:0] tmp;
    logic [7:0] sum;
    logic [39:0] word;
    logic [7:0] w;
    bit want;
    bit noise;
    bit zero_ok;
    bit one_ok;
    zero_ok = cfg_regs[REG_BIT_SPLIT_WIDTH] > cfg_regs[REG_ZERO_WIDTH_LOW];
    one_ok = cfg_regs[REG_ONE_WIDTH_HIGH] > cfg_regs[REG_BIT_SPLIT_WIDTH];
    case ($urandom_range(7))
      0: hum = '0;
      1: hum = 16'hFFFF;
      default: hum = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0: tmp = '0;
      1: tmp = 16'h8000;
      2: tmp = 16'h7FFF;
      3: tmp = 16'hFFFF;
      default: tmp = 16'($urandom);
    endcase
    sum = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
    if ($urandom_range(4) == 0) sum = 8'($urandom);
    word = {hum, tmp, sum};

    push_item(ACT_START, 8'($urandom), 1'b0, BLANK);
    while (rd_phase inside {PH_HOST_LOW, PH_HOST_HIGH, PH_WAIT_RESP, PH_SENS_HIGH, PH_XFER}) begin
      noise = $urandom_range(99) < 8;
      if (rd_phase inside {PH_HOST_LOW, PH_HOST_HIGH}) begin
        if (noise) push_item($urandom_range(1) ? ACT_START : ACT_EDGE, 8'($urandom), 1'b0, BLANK);
        else push_item(ACT_TIMER, 8'($urandom), 1'b0, BLANK);
      end else if (noise) begin
        // rare timeout aborts the read
        if ($urandom_range(19) == 0) push_item(ACT_TIMER, 8'($urandom), 1'b0, BLANK);
        else push_item(ACT_EDGE, 8'($urandom), 1'b0, BLANK);
      end else if (rd_phase == PH_XFER) begin
        want = word[39 - rd_bits];
        if (want && !one_ok) want = 1'b0;
        if (!want && !zero_ok) want = 1'b1;
        if (want)
          w = 8'($urandom_range(cfg_regs[REG_ONE_WIDTH_HIGH],
                                cfg_regs[REG_BIT_SPLIT_WIDTH] + 1));
        else
          w = 8'($urandom_range(cfg_regs[REG_BIT_SPLIT_WIDTH],
                                cfg_regs[REG_ZERO_WIDTH_LOW] + 1));
        push_item(ACT_EDGE, w, 1'b0, BLANK);
      end else begin
        w = 8'($urandom_range(cfg_regs[REG_RESP_WIDTH_HIGH] - 1,
                              cfg_regs[REG_RESP_WIDTH_LOW] + 1));
        push_item(ACT_EDGE, w, 1'b0, BLANK);
      end
    end
    if (rd_phase == PH_CHECK) begin
      if ($urandom_range(3) == 0) push_item(ACT_TIMER, 8'($urandom), 1'b0, BLANK);
      push_item(ACT_CHECK, 8'($urandom), 1'b0, BLANK);
      if ($urandom_range(2) == 0) push_item(ACT_CHECK, 8'($urandom), 1'b0, BLANK);
    end
  endtask

  task automatic check_field(input string name, input logic signed [15:0] exp_v,
                             input logic signed [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      err_count++;
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status_q.size() == 0) begin
        $error("result transfer with no expected status pending");
        err_count++;
      end else begin
        head_r = pending_status_q.pop_front();
        check_field("state_code", head_r.state_code, out_state_code);
        check_field("start_accepted", head_r.start_accepted, out_start_accepted);
        check_field("line_drive_low", head_r.line_drive_low, out_line_drive_low);
        check_field("line_is_input", head_r.line_is_input, out_line_is_input);
        check_field("edge_is_rising", head_r.edge_is_rising, out_edge_is_rising);
        check_field("timer_compare", head_r.timer_compare, out_timer_compare);
        check_field("timer_running", head_r.timer_running, out_timer_running);
        check_field("humidity_whole", head_r.humidity_whole, out_humidity_whole);
        check_field("humidity_tenths", head_r.humidity_tenths, out_humidity_tenths);
        check_field("temperature_whole", head_r.temperature_whole, out_temperature_whole);
        check_field("temperature_tenths", head_r.temperature_tenths,
                    out_temperature_tenths);
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[$];
    int seg_start;
    bit frame_ok;

    // reset state: stopped, line output high, rising edge, timer off
    dir_rows.push_back('{ACT_CHECK, 8'd0, 1'b1, status_word(PH_STOPPED, 0, 0, 0, 1, 8'd255, 0)});
    dir_rows.push_back('{ACT_TIMER, 8'd0, 1'b1, status_word(PH_STOPPED, 0, 0, 0, 1, 8'd255, 0)});
    dir_rows.push_back('{ACT_EDGE, 8'd255, 1'b1, status_word(PH_STOPPED, 0, 0, 0, 1, 8'd255, 0)});
    dir_rows.push_back('{ACT_START, 8'd0, 1'b1, status_word(PH_HOST_LOW, 1, 1, 0, 1, 8'd255, 1)});
    // busy start is refused
    dir_rows.push_back('{ACT_START, 8'd0, 1'b1, status_word(PH_HOST_LOW, 0, 1, 0, 1, 8'd255, 1)});
    dir_rows.push_back('{ACT_EDGE, 8'd80, 1'b0, BLANK});
    dir_rows.push_back('{ACT_TIMER, 8'd0, 1'b0, BLANK});
    dir_rows.push_back('{ACT_TIMER, 8'd0, 1'b0, BLANK});
    dir_rows.push_back('{ACT_TIMER, 8'd0, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd60, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd100, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd80, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd61, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd50, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd0, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd161, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd51, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd110, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd111, 1'b0, BLANK});
    dir_rows.push_back('{ACT_EDGE, 8'd160, 1'b0, BLANK});
    dir_rows.push_back('{ACT_CHECK, 8'd255, 1'b0, BLANK});
    // timeout mid-transfer
    dir_rows.push_back('{ACT_TIMER, 8'd0, 1'b1, status_word(PH_NO_RESP, 0, 0, 0, 0, 8'd255, 0)});
    dir_rows.push_back('{ACT_START, 8'd0, 1'b1, status_word(PH_HOST_LOW, 1, 1, 0, 0, 8'd255, 1)});
    dir_rows.push_back('{ACT_EDGE, 8'd255, 1'b0, BLANK});

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) push_item(dir_rows[i].act, dir_rows[i].width, dir_rows[i].typed,
                                    dir_rows[i].res);

    for (int s = 0; s < NUM_SETS; s++) begin
      case (s / 2)
        0: begin send_idle_pct = 27; recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      wait_results_idle();
      load_cfg(s);
      frame_ok = int'(cfg_regs[REG_RESP_WIDTH_HIGH]) >= int'(cfg_regs[REG_RESP_WIDTH_LOW]) + 2 &&
                 (cfg_regs[REG_BIT_SPLIT_WIDTH] > cfg_regs[REG_ZERO_WIDTH_LOW] ||
                  cfg_regs[REG_ONE_WIDTH_HIGH] > cfg_regs[REG_BIT_SPLIT_WIDTH]);
      seg_start = items_sent;
      while (items_sent - seg_start < SEG_ITEMS) begin
        if (frame_ok && $urandom_range(99) < 85) run_frame();
        else repeat ($urandom_range(5, 1)) push_noise();
      end
    end

    wait_results_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/swsfr_pkg.sv
design/swsfr_in_stage.sv
design/swsfr_core.sv
design/swsfr_out_stage.sv
design/single_wire_sensor_frame_reader.sv
design/swsfr_checker.sv
tb/sv/single_wire_sensor_frame_reader_tb.sv
